/* design/pprm_pkg.sv */
// ============================================================================
// pprm_pkg
// Shared types and constants for the pulse period speed meter: field widths,
// register reset values, configuration register indexes and sequencer states.
// ============================================================================
package pprm_pkg;

    // Field and state widths
    localparam int COUNTER_BITS = 16;
    localparam int NUM_W        = 32;
    localparam int RPM_W        = 16;
    localparam int WRAP_W       = 3;
    localparam int CFG_IDX_W    = 2;
    localparam int CFG_DATA_W   = 32;

    // Wrap count saturates here
    localparam logic [WRAP_W-1:0] WRAP_MAX = 3'd7;

    // Register reset values
    localparam logic [NUM_W-1:0]  RST_RPM_NUMERATOR = 32'd60000000;
    localparam logic [RPM_W-1:0]  RST_RPM_LIMIT     = 16'd15000;
    localparam logic [WRAP_W-1:0] RST_STALL_WRAPS   = 3'd4;

    // Configuration register indexes
    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_RPM_NUMERATOR = 2'd0,
        CFG_RPM_LIMIT     = 2'd1,
        CFG_STALL_WRAPS   = 2'd2
    } t_cfg_idx;

    // Sequencer states
    typedef enum logic [1:0] {
        ST_IDLE,
        ST_DIV,
        ST_WB
    } t_state;

endpackage

/* design/pprm_div.sv */
// ============================================================================
// pprm_div
// Restoring divider, one quotient bit per cycle. A start pulse loads the
// operands; done pulses for one cycle once the quotient is final, and the
// quotient then holds until the next start.
// ============================================================================
module pprm_div #(
    parameter int NUM_W = pprm_pkg::NUM_W,
    parameter int DIV_W = pprm_pkg::COUNTER_BITS + pprm_pkg::WRAP_W
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_start,
    input  logic [NUM_W-1:0] i_numerator,
    input  logic [DIV_W-1:0] i_divisor,
    output logic             o_done,
    output logic [NUM_W-1:0] o_quotient
);

    localparam int CNT_W = $clog2(NUM_W);
    localparam logic [CNT_W-1:0] CNT_LAST = CNT_W'(NUM_W - 1);

    logic             r_busy;
    logic             r_done;
    logic [CNT_W-1:0] r_cnt;
    logic [DIV_W-1:0] r_rem;
    logic [DIV_W-1:0] r_div;
    logic [NUM_W-1:0] r_quo;

    logic [DIV_W:0]   w_trial;
    logic [DIV_W:0]   w_diff;
    logic             w_ge;

    // Shift in the next numerator bit and try a subtract
    always_comb begin
        w_trial = {r_rem, r_quo[NUM_W-1]};
        w_diff  = w_trial - {1'b0, r_div};
        w_ge    = !w_diff[DIV_W];
    end

    // Control: busy flag, step count, done pulse
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= '0;
            end else if (r_busy) begin
                r_cnt <= r_cnt + 1'b1;
                if (r_cnt == CNT_LAST) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    // Datapath: remainder and numerator/quotient shift register
    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_rem <= '0;
            r_div <= i_divisor;
            r_quo <= i_numerator;
        end else if (r_busy) begin
            r_rem <= w_ge ? w_diff[DIV_W-1:0] : w_trial[DIV_W-1:0];
            r_quo <= {r_quo[NUM_W-2:0], w_ge};
        end
    end

    assign o_done     = r_done;
    assign o_quotient = r_quo;

endmodule

/* design/pulse_period_rpm_meter_top.sv */
// ============================================================================
// pulse_period_rpm_meter_top
// Engine speed meter by period measurement. One input item is one tick of
// the measuring clock with a pulse flag; one result item follows each item.
// ============================================================================
// Each accepted item yields exactly one result (rpm, stalled) held in an
// output register. A tick without a pulse, or a pulse with a zero period,
// loads that register as it is accepted. A pulse with a nonzero period
// starts the restoring divider (one quotient bit per cycle); the sequencer
// then sees the divider's done flag, and the speed is clamped and written
// back once the output register is free. The input stalls while a division
// runs or waits for write-back, and while the output register holds a result
// that the receiver is stalling. Configuration writes are always taken and
// should only be made while the block is idle.
module pulse_period_rpm_meter_top #(
    parameter int COUNTER_BITS = pprm_pkg::COUNTER_BITS
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    // input items
    input  logic                            i_in_valid,
    output logic                            o_in_stall,
    input  logic                            i_pulse,
    // result items
    output logic                            o_out_valid,
    input  logic                            i_out_stall,
    output logic [pprm_pkg::RPM_W-1:0]      o_rpm,
    output logic                            o_stalled,
    // configuration writes
    input  logic                            i_cfg_valid,
    output logic                            o_cfg_ready,
    input  logic [pprm_pkg::CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [pprm_pkg::CFG_DATA_W-1:0] i_cfg_data
);

    localparam int PERIOD_W = COUNTER_BITS + pprm_pkg::WRAP_W;
    localparam int NUM_W    = pprm_pkg::NUM_W;
    localparam int RPM_W    = pprm_pkg::RPM_W;
    localparam int WRAP_W   = pprm_pkg::WRAP_W;

    // Configuration registers
    logic [NUM_W-1:0]        r_numerator;
    logic [RPM_W-1:0]        r_limit;
    logic [WRAP_W-1:0]       r_stall_wraps;

    // Measurement state
    logic [COUNTER_BITS-1:0] r_tick;
    logic [WRAP_W-1:0]       r_wrap;
    logic [RPM_W-1:0]        r_speed;

    // Output register
    logic                    r_out_valid;
    logic [RPM_W-1:0]        r_rpm;
    logic                    r_stalled;

    // Sequencer
    pprm_pkg::t_state        r_state;
    pprm_pkg::t_state        n_state;

    logic                    w_out_free;
    logic                    w_accept;
    logic                    w_div_start;
    logic                    w_tick_load;
    logic                    w_wb_load;
    logic [PERIOD_W-1:0]     w_period;
    logic                    w_period_zero;
    logic                    w_div_done;
    logic [NUM_W-1:0]        w_quotient;

    logic [COUNTER_BITS-1:0] n_tick;
    logic [WRAP_W-1:0]       n_wrap;
    logic [RPM_W-1:0]        n_speed;
    logic [RPM_W-1:0]        w_clamped;

    assign w_out_free    = !r_out_valid || !i_out_stall;
    assign w_period      = {r_wrap, r_tick};
    assign w_period_zero = (w_period == '0);

    // Next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            pprm_pkg::ST_IDLE: begin
                if (w_accept && i_pulse && !w_period_zero) n_state = pprm_pkg::ST_DIV;
            end
            pprm_pkg::ST_DIV: begin
                if (w_div_done) n_state = pprm_pkg::ST_WB;
            end
            pprm_pkg::ST_WB: begin
                if (w_out_free) n_state = pprm_pkg::ST_IDLE;
            end
            default: n_state = pprm_pkg::ST_IDLE;
        endcase
    end

    // Sequencer outputs
    always_comb begin
        o_in_stall  = 1'b1;
        w_div_start = 1'b0;
        w_tick_load = 1'b0;
        w_wb_load   = 1'b0;
        case (r_state)
            pprm_pkg::ST_IDLE: begin
                o_in_stall  = !w_out_free;
                w_div_start = w_accept && i_pulse && !w_period_zero;
                w_tick_load = w_accept && !(i_pulse && !w_period_zero);
            end
            pprm_pkg::ST_DIV: begin
                o_in_stall = 1'b1;
            end
            pprm_pkg::ST_WB: begin
                w_wb_load = w_out_free;
            end
            default: o_in_stall = 1'b1;
        endcase
    end

    assign w_accept = i_in_valid && !o_in_stall;

    // Divider: numerator over period
    pprm_div #(
        .NUM_W (NUM_W),
        .DIV_W (PERIOD_W)
    ) u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (w_div_start),
        .i_numerator(r_numerator),
        .i_divisor  (w_period),
        .o_done     (w_div_done),
        .o_quotient (w_quotient)
    );

    // Clamp the quotient to the limit
    assign w_clamped = (w_quotient > {{(NUM_W - RPM_W){1'b0}}, r_limit})
                     ? r_limit : w_quotient[RPM_W-1:0];

    // Tick update: pulse with zero period, or counter advance
    always_comb begin
        n_tick  = r_tick + 1'b1;
        n_wrap  = r_wrap;
        n_speed = r_speed;
        if (i_pulse) begin
            n_tick  = '0;
            n_wrap  = '0;
            n_speed = r_limit;
        end else if (&r_tick) begin
            if (r_wrap != pprm_pkg::WRAP_MAX) n_wrap = r_wrap + 1'b1;
            if (n_wrap > r_stall_wraps) n_speed = '0;
        end
    end

    // Configuration writes
    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_numerator   <= pprm_pkg::RST_RPM_NUMERATOR;
            r_limit       <= pprm_pkg::RST_RPM_LIMIT;
            r_stall_wraps <= pprm_pkg::RST_STALL_WRAPS;
        end else if (i_cfg_valid && o_cfg_ready) begin
            case (i_cfg_index)
                pprm_pkg::CFG_RPM_NUMERATOR: r_numerator   <= i_cfg_data[NUM_W-1:0];
                pprm_pkg::CFG_RPM_LIMIT:     r_limit       <= i_cfg_data[RPM_W-1:0];
                pprm_pkg::CFG_STALL_WRAPS:   r_stall_wraps <= i_cfg_data[WRAP_W-1:0];
                default: ;
            endcase
        end
    end

    // Sequencer and measurement state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= pprm_pkg::ST_IDLE;
            r_tick  <= '0;
            r_wrap  <= '0;
            r_speed <= '0;
        end else begin
            r_state <= n_state;
            if (w_tick_load) begin
                r_tick  <= n_tick;
                r_wrap  <= n_wrap;
                r_speed <= n_speed;
            end else if (w_div_start) begin
                r_tick <= '0;
                r_wrap <= '0;
            end else if (w_wb_load) begin
                r_speed <= w_clamped;
            end
        end
    end

    // Output register: load a result, drop it once taken
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_tick_load || w_wb_load) begin
            r_out_valid <= 1'b1;
        end else if (!i_out_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_tick_load) begin
            r_rpm     <= n_speed;
            r_stalled <= (n_wrap > r_stall_wraps);
        end else if (w_wb_load) begin
            r_rpm     <= w_clamped;
            r_stalled <= 1'b0;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_rpm       = r_rpm;
    assign o_stalled   = r_stalled;

    // Divider finishes only while the sequencer waits for it
    a_done_in_div: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_div_done |-> (r_state == pprm_pkg::ST_DIV))
        else $error("divider done outside of the divide state");

    // A division start clears the period counters for the next measurement
    a_start_clears: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_div_start |=> (r_state == pprm_pkg::ST_DIV && r_tick == '0 && r_wrap == '0))
        else $error("division started without clearing the period counters");

    // A write-back delivers a result that is never marked stalled
    a_wb_not_stalled: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_wb_load |=> (r_out_valid && !r_stalled && r_state == pprm_pkg::ST_IDLE))
        else $error("pulse result written back as stalled");

endmodule

/* dv/tb_pulse_period_rpm_meter_top.sv */
`timescale 1ns / 100ps
// ============================================================================
// tb_pulse_period_rpm_meter_top
// Self-checking bench for the pulse period speed meter. A table of directed
// ticks and register loads runs first, then random pulse trains under several
// register settings; in all but the first, both handshake sides idle at random.
// Results are checked per field by an in-bench speed predictor or typed value.
// ============================================================================
module tb_pulse_period_rpm_meter_top;

    localparam int          COUNTER_BITS = pprm_pkg::COUNTER_BITS;
    localparam int          NUM_W        = pprm_pkg::NUM_W;
    localparam int          RPM_W        = pprm_pkg::RPM_W;
    localparam int          WRAP_W       = pprm_pkg::WRAP_W;
    localparam int          CFG_IDX_W    = pprm_pkg::CFG_IDX_W;
    localparam int          CFG_DATA_W   = pprm_pkg::CFG_DATA_W;

    localparam int          RESET_CYCLES = 7;
    localparam int          DRAIN_CYCLES = 40;       // one division plus margin
    localparam int unsigned CYCLE_LIMIT  = 4000000;
    localparam int          PRINT_MAX    = 50;
    localparam int          PHASES       = 6;
    localparam int          PHASE_ITEMS  = 250;

    typedef struct packed {
        logic [RPM_W-1:0] rpm;
        logic             stalled;
    } t_meter_out;

    typedef enum logic {
        ROW_ITEM,
        ROW_CFG
    } t_row_kind;

    // One directed step: a tick item, or a load of all three registers
    typedef struct packed {
        t_row_kind         kind;
        logic              pulse;
        logic              typed;
        logic [RPM_W-1:0]  rpm;
        logic              stalled;
        logic [NUM_W-1:0]  num;
        logic [RPM_W-1:0]  lim;
        logic [WRAP_W-1:0] stall;
    } t_dir_row;

    logic                  i_clk       = 1'b0;
    logic                  i_rst_n     = 1'b0;
    logic                  i_in_valid  = 1'b0;
    logic                  o_in_stall;
    logic                  i_pulse     = 1'b0;
    logic                  o_out_valid;
    logic                  i_out_stall = 1'b0;
    logic [RPM_W-1:0]      o_rpm;
    logic                  o_stalled;
    logic                  i_cfg_valid = 1'b0;
    logic                  o_cfg_ready;
    logic [CFG_IDX_W-1:0]  i_cfg_index = pprm_pkg::CFG_RPM_NUMERATOR;
    logic [CFG_DATA_W-1:0] i_cfg_data  = '0;

    // Predictor state and its copy of the registers
    logic [COUNTER_BITS-1:0] m_ticks = '0;
    logic [WRAP_W-1:0]       m_wraps = '0;
    logic [RPM_W-1:0]        m_speed = '0;
    logic [NUM_W-1:0]        m_num   = pprm_pkg::RST_RPM_NUMERATOR;
    logic [RPM_W-1:0]        m_lim   = pprm_pkg::RST_RPM_LIMIT;
    logic [WRAP_W-1:0]       m_stall = pprm_pkg::RST_STALL_WRAPS;

    t_meter_out  speed_expect_q[$];
    int          mismatch_cnt = 0;
    int unsigned cycle_cnt    = 0;
    bit          tx_idle      = 1'b0;
    bit          rx_idle      = 1'b0;
    int          rx_hold_req  = 0;
    int          rx_hold      = 0;

    t_dir_row dir_rows [24] = '{
        // zero period right after reset gives the limit
        '{ROW_ITEM, 1'b1, 1'b1, 16'd15000, 1'b0, 32'd0, 16'd0, 3'd0},
        '{ROW_ITEM, 1'b0, 1'b1, 16'd15000, 1'b0, 32'd0, 16'd0, 3'd0},
        // one-tick period, clamped to the limit
        '{ROW_ITEM, 1'b1, 1'b1, 16'd15000, 1'b0, 32'd0, 16'd0, 3'd0},
        '{ROW_CFG,  1'b0, 1'b0, 16'd0,     1'b0, 32'd0, 16'd65535, 3'd7},
        '{ROW_ITEM, 1'b0, 1'b1, 16'd15000, 1'b0, 32'd0, 16'd0, 3'd0},
        // zero numerator over a nonzero period
        '{ROW_ITEM, 1'b1, 1'b1, 16'd0,     1'b0, 32'd0, 16'd0, 3'd0},
        // zero period still gives the limit
        '{ROW_ITEM, 1'b1, 1'b1, 16'd65535, 1'b0, 32'd0, 16'd0, 3'd0},
        '{ROW_CFG,  1'b0, 1'b0, 16'd0,     1'b0, 32'hFFFF_FFFF, 16'd65535, 3'd7},
        '{ROW_ITEM, 1'b0, 1'b1, 16'd65535, 1'b0, 32'd0, 16'd0, 3'd0},
        '{ROW_ITEM, 1'b0, 1'b1, 16'd65535, 1'b0, 32'd0, 16'd0, 3'd0},
        // largest numerator, clamped at the top of the range
        '{ROW_ITEM, 1'b1, 1'b1, 16'd65535, 1'b0, 32'd0, 16'd0, 3'd0},
        '{ROW_CFG,  1'b0, 1'b0, 16'd0,     1'b0, 32'hFFFF_FFFF, 16'd0, 3'd0},
        '{ROW_ITEM, 1'b0, 1'b1, 16'd65535, 1'b0, 32'd0, 16'd0, 3'd0},
        // limit of zero clamps everything
        '{ROW_ITEM, 1'b1, 1'b1, 16'd0,     1'b0, 32'd0, 16'd0, 3'd0},
        '{ROW_CFG,  1'b0, 1'b0, 16'd0,     1'b0, 32'd1000, 16'd65535, 3'd3},
        '{ROW_ITEM, 1'b0, 1'b0, 16'd0,     1'b0, 32'd0, 16'd0, 3'd0},
        '{ROW_ITEM, 1'b0, 1'b0, 16'd0,     1'b0, 32'd0, 16'd0, 3'd0},
        '{ROW_ITEM, 1'b0, 1'b0, 16'd0,     1'b0, 32'd0, 16'd0, 3'd0},
        '{ROW_ITEM, 1'b1, 1'b0, 16'd0,     1'b0, 32'd0, 16'd0, 3'd0},
        '{ROW_CFG,  1'b0, 1'b0, 16'd0,     1'b0, 32'd1, 16'd65535, 3'd6},
        '{ROW_ITEM, 1'b0, 1'b0, 16'd0,     1'b0, 32'd0, 16'd0, 3'd0},
        '{ROW_ITEM, 1'b1, 1'b0, 16'd0,     1'b0, 32'd0, 16'd0, 3'd0},
        '{ROW_ITEM, 1'b1, 1'b1, 16'd65535, 1'b0, 32'd0, 16'd0, 3'd0},
        '{ROW_ITEM, 1'b0, 1'b0, 16'd0,     1'b0, 32'd0, 16'd0, 3'd0}
    };

    pulse_period_rpm_meter_top dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_stall  (o_in_stall),
        .i_pulse     (i_pulse),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_rpm       (o_rpm),
        .o_stalled   (o_stalled),
        .i_cfg_valid (i_cfg_valid),
        .o_cfg_ready (o_cfg_ready),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data)
    );

    always begin
        #6 i_clk = 1'b1;
        #6 i_clk = 1'b0;
    end

    // Mostly short idles, now and then a long one
    function automatic int idle_len();
        int len;
        if ($urandom_range(0, 9) != 0)
            len = $urandom_range(1, 3);
        else
            len = $urandom_range(20, 60);
        return len;
    endfunction

    // Advance the predicted meter by one tick and return the result item
    task automatic predict_speed(input logic pulse, output t_meter_out res);
        logic [WRAP_W+COUNTER_BITS-1:0] period;
        logic [NUM_W-1:0]               quot;
        if (pulse) begin
            period = {m_wraps, m_ticks};
            if (period == '0)
                quot = NUM_W'(m_lim);
            else
                quot = m_num / period;
            if (quot > m_lim)
                quot = NUM_W'(m_lim);
            m_speed = quot[RPM_W-1:0];
            m_ticks = '0;
            m_wraps = '0;
        end else begin
            m_ticks = m_ticks + 1'b1;
            if (m_ticks == '0) begin
                if (m_wraps != pprm_pkg::WRAP_MAX)
                    m_wraps = m_wraps + 1'b1;
                if (m_wraps > m_stall)
                    m_speed = '0;
            end
        end
        res.rpm     = m_speed;
        res.stalled = (m_wraps > m_stall);
    endtask

    // Drop input valid and hold until every expected result has come
    task automatic wait_drained();
        i_in_valid <= 1'b0;
        while (speed_expect_q.size() != 0)
            @(posedge i_clk);
    endtask

    // Load all three registers while the meter is idle
    task automatic load_config(input logic [NUM_W-1:0] num, input logic [RPM_W-1:0] lim,
                               input logic [WRAP_W-1:0] stall);
        wait_drained();
        for (int k = 0; k < 3; k++) begin
            i_cfg_valid <= 1'b1;
            case (k)
                0: begin
                    i_cfg_index <= pprm_pkg::CFG_RPM_NUMERATOR;
                    i_cfg_data  <= num;
                end
                1: begin
                    i_cfg_index <= pprm_pkg::CFG_RPM_LIMIT;
                    i_cfg_data  <= CFG_DATA_W'(lim);
                end
                default: begin
                    i_cfg_index <= pprm_pkg::CFG_STALL_WRAPS;
                    i_cfg_data  <= CFG_DATA_W'(stall);
                end
            endcase
            do @(posedge i_clk); while (!o_cfg_ready);
        end
        i_cfg_valid <= 1'b0;
        m_num   = num;
        m_lim   = lim;
        m_stall = stall;
    endtask

    // Offer one tick item; an expectation typed in overrides the prediction
    task automatic send_tick(input logic pulse, input logic typed,
                             input logic [RPM_W-1:0] rpm, input logic stalled);
        int         gap;
        t_meter_out res;
        gap = (tx_idle && $urandom_range(0, 3) == 0) ? idle_len() : 0;
        if (gap > 0) begin
            i_in_valid <= 1'b0;
            i_pulse    <= 1'($urandom_range(0, 1));
            repeat (gap) @(posedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_pulse    <= pulse;
        do @(posedge i_clk); while (o_in_stall);
        predict_speed(pulse, res);
        if (typed) begin
            res.rpm     = rpm;
            res.stalled = stalled;
        end
        speed_expect_q.push_back(res);
    endtask

    task automatic report_mismatch(input string field, input int unsigned want,
                                   input int unsigned got);
        mismatch_cnt++;
        if (mismatch_cnt <= PRINT_MAX)
            $display("%0t: %s expected %0d, actual %0d", $time, field, want, got);
    endtask

    // Receiver: random stalls plus any long hold-off requested by the stimulus
    always @(posedge i_clk) begin
        if (rx_hold_req > 0) begin
            rx_hold     = rx_hold_req;
            rx_hold_req = 0;
        end
        if (rx_hold > 0) begin
            i_out_stall <= 1'b1;
            rx_hold--;
        end else if (rx_idle && $urandom_range(0, 3) == 0) begin
            i_out_stall <= 1'b1;
            rx_hold = idle_len() - 1;
        end else begin
            i_out_stall <= 1'b0;
        end
    end

    // Compare each accepted result with the oldest expectation
    always @(posedge i_clk) begin : check_results
        t_meter_out want;
        if (i_rst_n && o_out_valid && !i_out_stall) begin
            if (speed_expect_q.size() == 0) begin
                mismatch_cnt++;
                if (mismatch_cnt <= PRINT_MAX)
                    $display("%0t: result expected none, actual rpm %0d stalled %0d",
                             $time, o_rpm, o_stalled);
            end else begin
                want = speed_expect_q.pop_front();
                if (o_rpm !== want.rpm)
                    report_mismatch("rpm", want.rpm, o_rpm);
                if (o_stalled !== want.stalled)
                    report_mismatch("stalled", want.stalled, o_stalled);
            end
        end
    end

    // Watchdog
    always @(posedge i_clk) begin
        cycle_cnt++;
        if (cycle_cnt > CYCLE_LIMIT) begin
            $display("Mismatches found");
            $finish;
        end
    end

    initial begin : stimulus
        int                sent;
        int                len;
        int                sel;
        logic [NUM_W-1:0]  num;
        logic [RPM_W-1:0]  lim;
        logic [WRAP_W-1:0] stall;

        repeat (RESET_CYCLES) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Directed table
        foreach (dir_rows[r]) begin
            if (dir_rows[r].kind == ROW_CFG)
                load_config(dir_rows[r].num, dir_rows[r].lim, dir_rows[r].stall);
            else
                send_tick(dir_rows[r].pulse, dir_rows[r].typed, dir_rows[r].rpm,
                          dir_rows[r].stalled);
        end

        // Random pulse trains, one register setting per phase
        for (int phase = 0; phase < PHASES; phase++) begin
            case ($urandom_range(0, 3))
                0: num = $urandom;
                1: num = $urandom_range(1, 2000);
                2: num = $urandom_range(2000, 3000000);
                default: num = $urandom_range(0, 1) ? 32'hFFFF_FFFF : 32'd1;
            endcase
            case ($urandom_range(0, 3))
                0: lim = '1;
                1: lim = 16'($urandom);
                2: lim = 16'($urandom_range(0, 300));
                default: lim = $urandom_range(0, 1) ? 16'd0 : 16'($urandom_range(300, 5000));
            endcase
            stall = 3'($urandom_range(0, 7));
            if (phase == 0) begin
                num = '1;
                lim = '1;
            end
            load_config(num, lim, stall);
            tx_idle = (phase != 0);
            rx_idle = (phase != 0);
            // hold the receiver off so the meter backs up into its input
            if (phase == 2)
                rx_hold_req = 400;
            sent = 0;
            while (sent < PHASE_ITEMS) begin
                if (phase == 3 && sent >= PHASE_ITEMS / 2 && sent < PHASE_ITEMS / 2 + 20)
                    wait_drained();
                sel = $urandom_range(0, 9);
                if (sel == 9) begin
                    // noise: pulses at random, often back to back
                    repeat (6) send_tick(1'($urandom_range(0, 1)), 1'b0, '0, 1'b0);
                    sent += 6;
                end else begin
                    len = (sel < 6) ? $urandom_range(0, 8) : $urandom_range(9, 60);
                    repeat (len) send_tick(1'b0, 1'b0, '0, 1'b0);
                    send_tick(1'b1, 1'b0, '0, 1'b0);
                    sent += len + 1;
                end
            end
        end

        // Drain and let any stray result show up
        wait_drained();
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (mismatch_cnt == 0)
            $display("No mismatches found");
        else
            $display("Mismatches found");
        $finish;
    end

endmodule

/* pulse_period_rpm_meter_top.f */
design/pprm_pkg.sv
design/pprm_div.sv
design/pulse_period_rpm_meter_top.sv
dv/tb_pulse_period_rpm_meter_top.sv
